// ----- rtl/tls_pkg.sv -----
// ----------------------------------------------------------------------------
// tls_pkg: shared types and constants
// Item structs, register indexes, reset values and phase codes for the
// traffic light sequencer with night blink.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int PERIOD_BITS        = 16;
  localparam int CFG_INDEX_BITS     = 3;
  localparam int CFG_DATA_BITS      = 16;

  localparam logic [7:0]  GREEN_TIME_RESET     = 8'd10;
  localparam logic [7:0]  YELLOW_TIME_RESET    = 8'd3;
  localparam logic [7:0]  RED_TIME_RESET       = 8'd10;
  localparam logic [11:0] DARK_THRESHOLD_RESET = 12'd1000;
  localparam logic [15:0] SECOND_TICKS_RESET   = 16'd1000;
  localparam logic [15:0] BLINK_TICKS_RESET    = 16'd500;
  localparam logic [15:0] DEBOUNCE_TICKS_RESET = 16'd50;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GREEN_TIME     = 3'd0,
    REG_YELLOW_TIME    = 3'd1,
    REG_RED_TIME       = 3'd2,
    REG_DARK_THRESHOLD = 3'd3,
    REG_SECOND_TICKS   = 3'd4,
    REG_BLINK_TICKS    = 3'd5,
    REG_DEBOUNCE_TICKS = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_GREEN  = 2'd0,
    PHASE_YELLOW = 2'd1,
    PHASE_RED    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [11:0] light_level;
    logic        button_level;
    logic        remote_valid;
    logic        remote_value;
  } in_item_t;

  typedef struct packed {
    logic       green_lamp;
    logic       yellow_lamp;
    logic       red_lamp;
    logic       blue_lamp;
    logic       display_show;
    logic [7:0] display_value;
    logic [1:0] light_phase;
    logic       report_valid;
  } out_item_t;

endpackage

// ----- rtl/tls_timer.sv -----
// ----------------------------------------------------------------------------
// tls_timer: saturating tick timer step
// Next count and fire flag for one tick; fires when the count reaches the
// period, then restarts at zero.
// ----------------------------------------------------------------------------
module tls_timer #(
  parameter int TIMER_BITS = tls_pkg::TIMER_BITS_DEFAULT
) (
  input  logic [TIMER_BITS-1:0]          count,
  input  logic [tls_pkg::PERIOD_BITS-1:0] period,
  output logic                           fire,
  output logic [TIMER_BITS-1:0]          count_next
);
  import tls_pkg::*;

  localparam int CW = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;

  logic [TIMER_BITS-1:0] bumped;

  // saturate at all ones
  assign bumped = (&count) ? count : count + TIMER_BITS'(1);
  assign fire   = CW'(bumped) >= CW'(period);
  assign count_next = fire ? '0 : bumped;

endmodule

// ----- rtl/tls_core.sv -----
// ----------------------------------------------------------------------------
// tls_core: sequencer state and per-tick update
// Holds configuration and state; works out one result item per tick.
// ----------------------------------------------------------------------------
module tls_core #(
  parameter int TIMER_BITS = tls_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tls_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                take,
  input  tls_pkg::in_item_t                   item,
  output tls_pkg::out_item_t                  result
);
  import tls_pkg::*;

  localparam int CW = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;
  localparam logic [CW-1:0] LIM = CW'({TIMER_BITS{1'b1}});

  // configuration
  logic [7:0]             green_time, yellow_time, red_time;
  logic [11:0]            dark_threshold;
  logic [PERIOD_BITS-1:0] second_ticks, blink_ticks, debounce_ticks;

  // state
  phase_t                phase, phase_next;
  logic [7:0]            seconds_left, seconds_left_next;
  logic [TIMER_BITS-1:0] second_elapsed, blink_elapsed, debounce_elapsed;
  logic [TIMER_BITS-1:0] blink_elapsed_next;
  logic                  button_seen, button_seen_next;
  logic                  flash_level, flash_level_next;
  logic                  yellow_hold, yellow_hold_next;
  logic                  show_enabled, show_enabled_next;

  logic                  deb_fire, sec_fire, blink_fire;
  logic [TIMER_BITS-1:0] deb_count, sec_count, blink_count;
  logic                  night, report;
  logic [CW-1:0]         blink_cap;

  tls_timer #(.TIMER_BITS(TIMER_BITS)) u_deb (
    .count(debounce_elapsed), .period(debounce_ticks),
    .fire(deb_fire), .count_next(deb_count)
  );
  tls_timer #(.TIMER_BITS(TIMER_BITS)) u_sec (
    .count(second_elapsed), .period(second_ticks),
    .fire(sec_fire), .count_next(sec_count)
  );
  tls_timer #(.TIMER_BITS(TIMER_BITS)) u_blink (
    .count(blink_elapsed), .period(blink_ticks),
    .fire(blink_fire), .count_next(blink_count)
  );

  assign night     = item.light_level < dark_threshold;
  assign blink_cap = (CW'(blink_ticks) > LIM) ? LIM : CW'(blink_ticks);

  always_comb begin
    show_enabled_next  = item.remote_valid ? item.remote_value : show_enabled;
    button_seen_next   = button_seen;
    report             = 1'b0;
    phase_next         = phase;
    seconds_left_next  = seconds_left;
    flash_level_next   = flash_level;
    yellow_hold_next   = yellow_hold;
    blink_elapsed_next = blink_count;

    // button: act on a change seen at a sample point; release toggles
    if (deb_fire && (item.button_level != button_seen)) begin
      button_seen_next = item.button_level;
      if (item.button_level) begin
        show_enabled_next = ~show_enabled_next;
        report            = 1'b1;
      end
    end

    // countdown, phase advance on a step from zero
    if (sec_fire) begin
      if (seconds_left == 8'd0) begin
        case (phase)
          PHASE_GREEN: begin
            phase_next        = PHASE_YELLOW;
            seconds_left_next = yellow_time;
          end
          PHASE_YELLOW: begin
            phase_next        = PHASE_RED;
            seconds_left_next = red_time;
          end
          default: begin
            phase_next        = PHASE_GREEN;
            seconds_left_next = green_time;
          end
        endcase
      end else begin
        seconds_left_next = seconds_left - 8'd1;
      end
    end

    if (night) begin
      if (blink_fire) begin
        flash_level_next = ~flash_level;
        yellow_hold_next = ~flash_level;
      end
    end else begin
      yellow_hold_next = (phase_next == PHASE_YELLOW);
      // by day a firing does not restart the blink count
      if (blink_fire) begin
        blink_elapsed_next = blink_cap[TIMER_BITS-1:0];
      end
    end

    result.green_lamp    = !night && (phase_next == PHASE_GREEN);
    result.yellow_lamp   = yellow_hold_next;
    result.red_lamp      = !night && (phase_next == PHASE_RED);
    result.blue_lamp     = show_enabled_next;
    result.display_show  = show_enabled_next && !night;
    result.display_value = seconds_left_next;
    result.light_phase   = phase_next;
    result.report_valid  = report;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      green_time     <= GREEN_TIME_RESET;
      yellow_time    <= YELLOW_TIME_RESET;
      red_time       <= RED_TIME_RESET;
      dark_threshold <= DARK_THRESHOLD_RESET;
      second_ticks   <= SECOND_TICKS_RESET;
      blink_ticks    <= BLINK_TICKS_RESET;
      debounce_ticks <= DEBOUNCE_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GREEN_TIME:     green_time     <= cfg_data[7:0];
        REG_YELLOW_TIME:    yellow_time    <= cfg_data[7:0];
        REG_RED_TIME:       red_time       <= cfg_data[7:0];
        REG_DARK_THRESHOLD: dark_threshold <= cfg_data[11:0];
        REG_SECOND_TICKS:   second_ticks   <= cfg_data;
        REG_BLINK_TICKS:    blink_ticks    <= cfg_data;
        REG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PHASE_GREEN;
      seconds_left     <= GREEN_TIME_RESET;
      second_elapsed   <= '0;
      blink_elapsed    <= '0;
      debounce_elapsed <= '0;
      button_seen      <= 1'b1;
      flash_level      <= 1'b0;
      yellow_hold      <= 1'b0;
      show_enabled     <= 1'b1;
    end else if (take) begin
      phase            <= phase_next;
      seconds_left     <= seconds_left_next;
      second_elapsed   <= sec_count;
      blink_elapsed    <= blink_elapsed_next;
      debounce_elapsed <= deb_count;
      button_seen      <= button_seen_next;
      flash_level      <= flash_level_next;
      yellow_hold      <= yellow_hold_next;
      show_enabled     <= show_enabled_next;
    end
  end

`ifndef SYNTHESIS
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(phase) && $stable(seconds_left) && $stable(show_enabled))
    else $error("tls_core: state moved without an item");
  a_report_toggles: assert property (@(posedge clk) disable iff (rst)
    take && !item.remote_valid && result.report_valid |=>
      show_enabled != $past(show_enabled))
    else $error("tls_core: report without enable toggle");
  a_lamps: assert property (@(posedge clk) disable iff (rst)
    take |-> $onehot0({result.green_lamp, result.yellow_lamp, result.red_lamp}))
    else $error("tls_core: more than one lamp lit");
`endif

endmodule

// ----- rtl/tls_outq.sv -----
// ----------------------------------------------------------------------------
// tls_outq: two-entry result buffer
// Holds result items so a new item can enter while one waits downstream.
// ----------------------------------------------------------------------------
module tls_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tls_pkg::out_item_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output tls_pkg::out_item_t out_item
);
  import tls_pkg::*;

  out_item_t  slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = count[1];
  assign out_valid = count != 2'd0;
  assign out_item  = slot[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("tls_outq: push into full buffer");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("tls_outq: count out of range");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("tls_outq: pointers disagree with count");
`endif

endmodule

// ----- rtl/traffic_light_sequencer_night_blink_core.sv -----
// ----------------------------------------------------------------------------
// traffic_light_sequencer_night_blink_core: top level
// Traffic light sequencer with night flashing and button/remote display
// enable, one item per millisecond tick.
// ----------------------------------------------------------------------------
// Each accepted item is one tick. The core updates all state in the cycle of
// acceptance and the result item sits in a two-entry buffer from the next
// cycle on, so one item can be taken every cycle while the buffer has room;
// in_ready drops only while both buffer entries wait on out_ready. Phases run
// green, yellow, red; the seconds countdown steps every second_ticks ticks
// and reloads with the next phase's time on a step from zero. Below
// dark_threshold green and red go dark, yellow toggles every blink_ticks and
// the display blanks (display_value still carries the countdown). The button
// is sampled every debounce_ticks; a release toggles blue lamp and display
// enable and flags report_valid. A remote write sets the enable directly.
// Configuration writes take effect at once and are meant for idle periods;
// an index beyond the seven registers is ignored.
// ----------------------------------------------------------------------------
module traffic_light_sequencer_night_blink_core #(
  parameter int TIMER_BITS = tls_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [tls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tls_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // tick items in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tls_pkg::in_item_t                   in_item,
  // result items out
  output logic                                out_valid,
  input  logic                                out_ready,
  output tls_pkg::out_item_t                  out_item
);
  import tls_pkg::*;

  logic      take;
  logic      full;
  out_item_t result;

  // room in the buffer is all that gates a new tick
  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  tls_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (in_item),
    .result    (result)
  );

  tls_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_item (result),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
